// ===== src/tor_pkg.sv =====
// Package for the tty output ring buffer: sequencer states and fixed constants.
// No dependencies; used by scoped name from tor_store and tty_output_ring_buffer.
`default_nettype none
package tor_pkg;

  // Character that ends a line and starts a send in line mode
  localparam logic [7:0] NEWLINE = 8'h0A;

  // Fixed widths of the stream fields
  localparam int CHAR_W = 8;
  localparam int FREE_W = 6;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_EMIT
  } tor_state_t;

endpackage
`default_nettype wire

// ===== src/tor_modadd.sv =====
// Shared modular index adder: (a + b) wrapped once at DEPTH, plus the wrap flag.
// Uses tor_pkg only through its users; no package items needed here.
`default_nettype none
module tor_modadd #(
  parameter int DEPTH = 64
) (
  input  wire logic [$clog2(DEPTH)-1:0]   a,
  input  wire logic [$clog2(DEPTH+1)-1:0] b,
  output logic                            wrap,
  output logic [$clog2(DEPTH)-1:0]        sum_mod
);

  localparam int IW = $clog2(DEPTH);
  localparam int SW = IW + 1;

  logic [SW-1:0] raw;

  // Add, then fold once: a < DEPTH and b <= DEPTH keep the sum below 2*DEPTH
  always_comb begin
    raw     = SW'(a) + SW'(b);
    wrap    = (raw >= SW'(DEPTH));
    sum_mod = wrap ? IW'(raw - SW'(DEPTH)) : IW'(raw);
  end

endmodule
`default_nettype wire

// ===== src/tor_store.sv =====
// Character store: one write port, one read port with registered read data.
// Depends on tor_pkg for the character width.
`default_nettype none
module tor_store #(
  parameter int DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  wire logic [tor_pkg::CHAR_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic      [tor_pkg::CHAR_W-1:0]  rd_data
);

  logic [tor_pkg::CHAR_W-1:0] mem [DEPTH];

  // Write one character
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read and hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/tty_output_ring_buffer.sv =====
// Line-buffered circular transmit buffer. A put or completion that sends nothing
// gives its single word in the cycle after accept; one item per cycle while out is taken.
// A chunk runs a setup state, then per byte an adder/read state and an output-load state;
// the next item waits until the chunk's last word is loaded.
// Synchronous active-low reset clears counters, indexes, busy, raw mode and the
// sequencer; the character store is not cleared. Output stalls hold the output-load state.
`default_nettype none
module tty_output_ring_buffer #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_in
  input  wire logic        in_tuser,   // [0] mode
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [0] accepted, [8:1] send_byte,
                                       // [9] busy_flag, [15:10] free_space
  output logic             out_tuser,  // [0] send_valid
  output logic             out_tlast,  // send_last
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data    // raw_mode
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = (CW > tor_pkg::FREE_W) ? CW : tor_pkg::FREE_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] NEAR_C  = CW'(DEPTH - 5);
  localparam logic [CW-1:0] DM1_C   = CW'(DEPTH - 1);

  tor_pkg::tor_state_t state_r, state_nxt;

  logic [CW-1:0] sc_r, sc_nxt;
  logic [IW-1:0] ri_r, ri_nxt;
  logic [CW-1:0] inf_r, inf_nxt;
  logic          sending_r, sending_nxt;
  logic          raw_r;
  logic          acc_r, acc_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic                       out_valid_r;
  logic                       out_acc_r;
  logic                       out_sv_r;
  logic [tor_pkg::CHAR_W-1:0] out_byte_r;
  logic                       out_last_r;
  logic                       out_busy_r;
  logic [tor_pkg::FREE_W-1:0] out_free_r;

  logic                       ld;
  logic                       ld_acc;
  logic                       ld_sv;
  logic [tor_pkg::CHAR_W-1:0] ld_byte;
  logic                       ld_last;
  logic [tor_pkg::FREE_W-1:0] ld_free;
  logic [FW-1:0]              free_diff;

  logic          in_fire;
  logic          is_put;
  logic          out_free;
  logic          start_chunk;
  logic          last_byte;

  logic [CW-1:0] add_b;
  logic          add_wrap;
  logic [IW-1:0] add_mod;

  logic                       wr_en;
  logic                       rd_en;
  logic [tor_pkg::CHAR_W-1:0] rd_data;

  // Handshakes
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == tor_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign is_put    = !in_tuser;
  assign cfg_ready = 1'b1;
  assign last_byte = (k_r == (n_r - CW'(1)));

  tor_modadd #(.DEPTH(DEPTH)) u_add (
    .a       (ri_r),
    .b       (add_b),
    .wrap    (add_wrap),
    .sum_mod (add_mod)
  );

  tor_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (add_mod),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (add_mod),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tor_pkg::ST_IDLE: begin
        if (start_chunk) state_nxt = tor_pkg::ST_START;
      end
      tor_pkg::ST_START: begin
        state_nxt = tor_pkg::ST_READ;
      end
      tor_pkg::ST_READ: begin
        state_nxt = tor_pkg::ST_EMIT;
      end
      tor_pkg::ST_EMIT: begin
        if (out_free) state_nxt = last_byte ? tor_pkg::ST_IDLE : tor_pkg::ST_READ;
      end
      default: state_nxt = tor_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output loads per state
  always_comb begin
    sc_nxt      = sc_r;
    ri_nxt      = ri_r;
    inf_nxt     = inf_r;
    sending_nxt = sending_r;
    acc_nxt     = acc_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    add_b       = sc_r;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    start_chunk = 1'b0;
    ld          = 1'b0;
    ld_acc      = 1'b0;
    ld_sv       = 1'b0;
    ld_byte     = '0;
    ld_last     = 1'b1;
    case (state_r)
      tor_pkg::ST_IDLE: begin
        add_b = is_put ? sc_r : inf_r;
        if (in_fire) begin
          if (is_put) begin
            if (sc_r == DEPTH_C) begin
              // full: drop the character
              ld = 1'b1;
            end else begin
              wr_en  = 1'b1;
              sc_nxt = sc_r + CW'(1);
              if ((raw_r || in_tdata == tor_pkg::NEWLINE || sc_nxt > NEAR_C)
                  && !sending_r) begin
                sending_nxt = 1'b1;
                acc_nxt     = 1'b1;
                start_chunk = 1'b1;
              end else begin
                ld     = 1'b1;
                ld_acc = 1'b1;
              end
            end
          end else if (!sending_r) begin
            // completion with nothing in flight
            ld = 1'b1;
          end else begin
            // retire the in-flight chunk
            sc_nxt  = (inf_r > sc_r) ? '0 : sc_r - inf_r;
            ri_nxt  = add_mod;
            inf_nxt = '0;
            acc_nxt = 1'b0;
            if (sc_nxt != '0) begin
              start_chunk = 1'b1;
            end else begin
              sending_nxt = 1'b0;
              ld          = 1'b1;
            end
          end
        end
      end
      tor_pkg::ST_START: begin
        // chunk ends at the wrap point or the end of the data
        add_b   = sc_r;
        n_nxt   = add_wrap ? (DEPTH_C - CW'(ri_r)) : sc_r;
        inf_nxt = n_nxt;
        k_nxt   = '0;
      end
      tor_pkg::ST_READ: begin
        add_b = k_r;
        rd_en = 1'b1;
      end
      tor_pkg::ST_EMIT: begin
        add_b = k_r;
        if (out_free) begin
          ld      = 1'b1;
          ld_acc  = acc_r;
          ld_sv   = 1'b1;
          ld_byte = rd_data;
          ld_last = last_byte;
          if (!last_byte) k_nxt = k_r + CW'(1);
        end
      end
      default: begin
        add_b = sc_r;
      end
    endcase
  end

  // Free space after this step, saturated at zero
  always_comb begin
    free_diff = FW'(DM1_C) - FW'(sc_nxt);
    ld_free   = (sc_nxt >= DM1_C) ? '0 : free_diff[tor_pkg::FREE_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tor_pkg::ST_IDLE;
      sc_r        <= '0;
      ri_r        <= '0;
      inf_r       <= '0;
      sending_r   <= 1'b0;
      raw_r       <= 1'b0;
      acc_r       <= 1'b0;
      n_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      ri_r        <= ri_nxt;
      inf_r       <= inf_nxt;
      sending_r   <= sending_nxt;
      acc_r       <= acc_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
      if (cfg_valid && cfg_ready) raw_r <= cfg_data;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (ld) begin
      out_acc_r  <= ld_acc;
      out_sv_r   <= ld_sv;
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
      out_busy_r <= sending_nxt;
      out_free_r <= ld_free;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_free_r, out_busy_r, out_byte_r, out_acc_r};
  assign out_tuser  = out_sv_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
